/* rtl/core/b64e_pkg.sv */
// Package for the base64 stream encoder: character entry type, group phase
// enum, queue sizing and the alphabet lookup. No dependencies.
package b64e_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned CharW     = 7;
  localparam int unsigned SymW      = 6;
  localparam int unsigned LeftW     = 4;
  localparam int unsigned MaxChars  = 4;
  localparam int unsigned IdxW      = $clog2(MaxChars);
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QueueCntW = $clog2(QueueDepth + 1);

  localparam logic [CharW-1:0] PadChar   = 7'd61;
  localparam logic [CharW-1:0] UpperBase = 7'd65;
  localparam logic [CharW-1:0] LowerBase = 7'd97;
  localparam logic [CharW-1:0] DigitBase = 7'd48;
  localparam logic [CharW-1:0] PlusChar  = 7'd43;
  localparam logic [CharW-1:0] SlashChar = 7'd47;

  typedef enum logic [1:0] {
    PhaseZero = 2'd0,
    PhaseOne  = 2'd1,
    PhaseTwo  = 2'd2
  } phase_e;

  // One entry holds every character that a single byte produces.
  typedef struct packed {
    logic [MaxChars-1:0][CharW-1:0] chars;
    logic [IdxW-1:0]                last_idx;
    logic                           is_last;
  } entry_t;

  function automatic logic [CharW-1:0] sym_ascii(input logic [SymW-1:0] v);
    logic [CharW-1:0] v7;
    logic [CharW-1:0] res;
    v7 = CharW'(v);
    if (v < 6'd26) begin
      res = UpperBase + v7;
    end else if (v < 6'd52) begin
      res = LowerBase + v7 - 7'd26;
    end else if (v < 6'd62) begin
      res = DigitBase + v7 - 7'd52;
    end else if (v == 6'd62) begin
      res = PlusChar;
    end else begin
      res = SlashChar;
    end
    return res;
  endfunction

endpackage

/* rtl/core/b64e_front.sv */
// Front end: accepts bytes, tracks the group phase and leftover bits, and
// builds one character entry per byte. Depends on b64e_pkg.
module b64e_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [b64e_pkg::ByteW-1:0]   data_byte_i,
  input  logic                         is_last_byte_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         q_full_i,
  output logic                         push_o,
  output b64e_pkg::entry_t             entry_o
);
  import b64e_pkg::*;

  phase_e           phase_q, phase_d;
  logic [LeftW-1:0] left_q, left_d;
  logic             fire;

  assign in_ready_o = !q_full_i;
  assign fire       = in_valid_i && !q_full_i;
  assign push_o     = fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhaseZero;
      left_q  <= '0;
    end else begin
      phase_q <= phase_d;
      left_q  <= left_d;
    end
  end

  always_comb begin
    entry_o.chars    = {MaxChars{PadChar}};
    entry_o.last_idx = '0;
    entry_o.is_last  = is_last_byte_i;
    phase_d          = phase_q;
    left_d           = left_q;
    unique case (phase_q)
      PhaseOne: begin
        entry_o.chars[0] = sym_ascii({left_q[1:0], data_byte_i[7:4]});
        left_d  = data_byte_i[3:0];
        phase_d = PhaseTwo;
        if (is_last_byte_i) begin
          entry_o.chars[1] = sym_ascii({data_byte_i[3:0], 2'b00});
          entry_o.last_idx = IdxW'(2);
        end
      end
      PhaseTwo: begin
        entry_o.chars[0] = sym_ascii({left_q, data_byte_i[7:6]});
        entry_o.chars[1] = sym_ascii(data_byte_i[5:0]);
        entry_o.last_idx = IdxW'(1);
        left_d  = '0;
        phase_d = PhaseZero;
      end
      default: begin
        entry_o.chars[0] = sym_ascii(data_byte_i[7:2]);
        left_d  = LeftW'(data_byte_i[1:0]);
        phase_d = PhaseOne;
        if (is_last_byte_i) begin
          entry_o.chars[1] = sym_ascii({data_byte_i[1:0], 4'b0000});
          entry_o.last_idx = IdxW'(3);
        end
      end
    endcase
    if (!fire) begin
      phase_d = phase_q;
      left_d  = left_q;
    end else if (is_last_byte_i) begin
      phase_d = PhaseZero;
      left_d  = '0;
    end
  end

endmodule

/* rtl/core/b64e_queue.sv */
// Short queue of character entries between the front and back ends.
// Depends on b64e_pkg.
module b64e_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  b64e_pkg::entry_t  entry_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output b64e_pkg::entry_t  head_o
);
  import b64e_pkg::*;

  localparam logic [QueuePtrW-1:0] LastPtr = QueuePtrW'(QueueDepth - 1);

  entry_t               mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0] cnt_q, cnt_d;
  logic                 do_push, do_pop;

  assign full_o  = (cnt_q == QueueCntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

/* rtl/core/b64e_back.sv */
// Back end: walks the head entry into the output register one character per
// cycle while the output is not stalled. Depends on b64e_pkg.
module b64e_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          empty_i,
  input  b64e_pkg::entry_t              head_i,
  output logic                          pop_o,
  output logic [b64e_pkg::CharW-1:0]    out_char_o,
  output logic                          is_last_char_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i
);
  import b64e_pkg::*;

  logic [IdxW-1:0]  idx_q, idx_d;
  logic             valid_q, valid_d;
  logic [CharW-1:0] char_q, char_d;
  logic             last_q, last_d;
  logic             advance, at_end;

  assign advance = !valid_q || out_ready_i;
  assign at_end  = (idx_q == head_i.last_idx);
  assign pop_o   = advance && !empty_i && at_end;

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    char_d  = char_q;
    last_d  = last_q;
    if (advance) begin
      valid_d = !empty_i;
      if (!empty_i) begin
        char_d = head_i.chars[idx_q];
        last_d = head_i.is_last && at_end;
        idx_d  = at_end ? '0 : idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    last_q <= last_d;
  end

  assign out_valid_o    = valid_q;
  assign out_char_o     = char_q;
  assign is_last_char_o = last_q;

endmodule

/* rtl/core/base64_stream_encoder_top.sv */
// Top level of the streaming base64 encoder.
// Depends on b64e_pkg, b64e_front, b64e_queue and b64e_back.
//
// Encodes one message byte per input word into standard-alphabet base64
// characters with '=' padding, one character per output word, and flags the
// final character of each message. The output register emits one character
// per cycle while output is not stalled. A byte yields one character as the
// first or second byte of a group, two as the third, and up to four as a
// final byte that carries padding; a full three-byte group yields four. A
// byte's first character passes through the queue, then the output register.
// A two-entry queue holds bytes during output stalls; input stalls when full.
module base64_stream_encoder_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [b64e_pkg::ByteW-1:0]  data_byte_i,
  input  logic                        is_last_byte_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  output logic [b64e_pkg::CharW-1:0]  out_char_o,
  output logic                        is_last_char_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i
);
  import b64e_pkg::*;

  entry_t push_entry;
  entry_t head_entry;
  logic   push, pop, q_full, q_empty;

  b64e_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .data_byte_i    (data_byte_i),
    .is_last_byte_i (is_last_byte_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .q_full_i       (q_full),
    .push_o         (push),
    .entry_o        (push_entry)
  );

  b64e_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .head_o  (head_entry)
  );

  b64e_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (q_empty),
    .head_i         (head_entry),
    .pop_o          (pop),
    .out_char_o     (out_char_o),
    .is_last_char_o (is_last_char_o),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i)
  );

endmodule

/* rtl/core/b64e_checker.sv */
// Port-level checker for the base64 stream encoder, bound to the top level.
// Depends on b64e_pkg and base64_stream_encoder_top.
module b64e_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic [b64e_pkg::ByteW-1:0]  data_byte_i,
  input logic                        is_last_byte_i,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic [b64e_pkg::CharW-1:0]  out_char_o,
  input logic                        is_last_char_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i
);
  import b64e_pkg::*;

  logic out_fire;
  assign out_fire = out_valid_o && out_ready_i;

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=>
      in_valid_i && $stable(data_byte_i) && $stable(is_last_byte_i))
    else $error("input word changed while stalled");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(out_char_o) && $stable(is_last_char_o))
    else $error("output word changed while stalled");

  a_legal_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (out_char_o >= 7'd65 && out_char_o <= 7'd90) ||
      (out_char_o >= 7'd97 && out_char_o <= 7'd122) ||
      (out_char_o >= 7'd48 && out_char_o <= 7'd57) ||
      out_char_o == PlusChar || out_char_o == SlashChar || out_char_o == PadChar)
    else $error("character outside base64 alphabet");

  a_pad_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && out_char_o == PadChar && !is_last_char_o |=>
      out_valid_o && out_char_o == PadChar)
    else $error("padding run broken");

  a_pad_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && out_char_o != PadChar |=>
      !(out_valid_o && out_char_o == PadChar && $past(is_last_char_o)))
    else $error("padding after final character");

endmodule

bind base64_stream_encoder_top b64e_checker u_checker (.*);

/* dv/testbench.sv */
// Self-checking testbench for base64_stream_encoder_top: a scoreboard class predicts the
// base64 characters of each accepted byte and checks every output word against them.
// Depends on b64e_pkg and the encoder RTL.

typedef struct packed {
  logic [b64e_pkg::CharW-1:0] code;
  logic                       last;
} b64_char_t;

class b64_char_board;
  string              symbols =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  b64e_pkg::phase_e   phase   = b64e_pkg::PhaseZero;
  logic [3:0]         left    = 4'h0;
  b64_char_t          pending[$];
  int                 errors  = 0;
  int                 n_bytes = 0;
  int                 n_chars = 0;
  int                 n_msgs  = 0;
  int                 closed_at[3] = '{0, 0, 0};

  function logic [b64e_pkg::CharW-1:0] symbol(logic [5:0] v);
    return b64e_pkg::CharW'(symbols[v]);
  endfunction

  function void push_char(logic [b64e_pkg::CharW-1:0] code, logic last);
    b64_char_t c;
    c.code = code;
    c.last = last;
    pending.push_back(c);
  endfunction

  task report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  function void note_byte(logic [7:0] b, logic last);
    n_bytes++;
    if (last) begin
      n_msgs++;
      closed_at[(phase == b64e_pkg::PhaseOne) ? 1 : (phase == b64e_pkg::PhaseTwo) ? 2 : 0]++;
    end
    case (phase)
      b64e_pkg::PhaseOne: begin
        push_char(symbol({left[1:0], b[7:4]}), 1'b0);
        left  = b[3:0];
        phase = b64e_pkg::PhaseTwo;
        if (last) begin
          push_char(symbol({left, 2'b00}), 1'b0);
          push_char(b64e_pkg::PadChar, 1'b1);
        end
      end
      b64e_pkg::PhaseTwo: begin
        push_char(symbol({left, b[7:6]}), 1'b0);
        push_char(symbol(b[5:0]), last);
        left  = 4'h0;
        phase = b64e_pkg::PhaseZero;
      end
      default: begin
        push_char(symbol(b[7:2]), 1'b0);
        left  = {2'b00, b[1:0]};
        phase = b64e_pkg::PhaseOne;
        if (last) begin
          push_char(symbol({left[1:0], 4'h0}), 1'b0);
          push_char(b64e_pkg::PadChar, 1'b0);
          push_char(b64e_pkg::PadChar, 1'b1);
        end
      end
    endcase
    if (last) begin
      phase = b64e_pkg::PhaseZero;
      left  = 4'h0;
    end
  endfunction

  task check_char(logic [b64e_pkg::CharW-1:0] code, logic last);
    b64_char_t want;
    n_chars++;
    if (pending.size() == 0) begin
      report_mismatch($sformatf("unexpected character 0x%02h last=%0b", code, last));
    end else begin
      want = pending.pop_front();
      if (code !== want.code) begin
        report_mismatch($sformatf("character 0x%02h, want 0x%02h", code, want.code));
      end
      if (last !== want.last) begin
        report_mismatch($sformatf("last flag %0b, want %0b on 0x%02h", last, want.last,
                                  want.code));
      end
    end
  endtask
endclass

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic                       clk_i          = 1'b0;
  logic                       rst_ni         = 1'b0;
  logic [b64e_pkg::ByteW-1:0] data_byte_i    = '0;
  logic                       is_last_byte_i = 1'b0;
  logic                       in_valid_i     = 1'b0;
  logic                       in_ready_o;
  logic [b64e_pkg::CharW-1:0] out_char_o;
  logic                       is_last_char_o;
  logic                       out_valid_o;
  logic                       out_ready_i    = 1'b0;

  b64_char_board board = new;
  bit            quiet = 1'b0;
  int            sent  = 0;

  base64_stream_encoder_top i_dut (
    .clk_i,
    .rst_ni,
    .data_byte_i,
    .is_last_byte_i,
    .in_valid_i,
    .in_ready_o,
    .out_char_o,
    .is_last_char_o,
    .out_valid_o,
    .out_ready_i
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        board.note_byte(data_byte_i, is_last_byte_i);
      end
      if (out_valid_o && out_ready_i) begin
        board.check_char(out_char_o, is_last_char_o);
      end
    end
  end

  initial begin
    int hold;
    hold = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold > 0) begin
        hold--;
        out_ready_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(0, 5);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task send_byte(logic [7:0] b, logic last);
    int gap;
    gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    data_byte_i    <= b;
    is_last_byte_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    sent++;
  endtask

  task send_message(logic [7:0] msg[$]);
    foreach (msg[i]) send_byte(msg[i], i == msg.size() - 1);
  endtask

  initial begin
    logic [7:0] msg[$];
    int         len;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_message('{8'h00});
    send_message('{8'hFF});
    send_message('{8'hFF, 8'h00});
    send_message('{8'h00, 8'hFF, 8'h80});
    send_message('{8'hFB, 8'hFF, 8'hBF, 8'h01});
    send_message('{8'h4D, 8'h61, 8'h6E, 8'h00, 8'hFF});
    send_message('{8'hFC, 8'h0F});

    while (sent < 270) begin
      if (sent > 220) quiet = 1'b1;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 9);
      msg.delete();
      repeat (len) begin
        case ($urandom_range(0, 9))
          0:       msg.push_back(8'h00);
          1:       msg.push_back(8'hFF);
          default: msg.push_back(8'($urandom_range(0, 255)));
        endcase
      end
      send_message(msg);
    end
    in_valid_i <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Encoded %0d bytes in %0d messages, %0d characters checked",
             board.n_bytes, board.n_msgs, board.n_chars);
    $display("Messages ending at group position 0/1/2: %0d/%0d/%0d",
             board.closed_at[0], board.closed_at[1], board.closed_at[2]);
    if (board.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
